FILE: design/mprs_pkg.sv
// shared constants, codes and types of the multi-pattern read screen
// depends on nothing; every other file of the block imports it

package mprs_pkg;

   // table size
   localparam int PATTERNS = 16;
   localparam int MAX_LEN  = 32;

   // item field widths
   localparam int CHAR_W = 8;
   localparam int TYPE_W = 2;
   localparam int IDX_W  = 4;
   localparam int POS_W  = 5;
   localparam int PLEN_W = 6;
   localparam int CNT_W  = 32;

   // derived widths
   localparam int LEN_W  = $clog2(MAX_LEN + 1);
   localparam int ROW_W  = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;
   localparam int ADDR_W = (IDX_W > ROW_W) ? IDX_W : ROW_W;

   // request codes
   localparam logic [TYPE_W-1:0] REQ_READ       = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_WRITE_CHAR = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_SET_LEN    = 2'd2;

   typedef logic [CHAR_W-1:0] char_type;
   typedef logic [LEN_W-1:0] len_type;
   typedef logic [MAX_LEN-1:0][CHAR_W-1:0] line_type;

   // table write command broadcast to every pattern row
   typedef struct packed {
      logic             wr_char;
      logic             wr_len;
      logic [IDX_W-1:0] idx;
      logic [POS_W-1:0] pos;
      char_type         ch;
      len_type          len;
   } load_type;

   // window chain control
   typedef struct packed {
      logic shift;
      logic clear;
   } shift_ctl_type;

   // one result item
   typedef struct packed {
      logic             removed;
      logic [CNT_W-1:0] clean;
      logic [CNT_W-1:0] filtered;
   } result_type;

endpackage

FILE: design/mprs_req_if.sv
// request channel of the read screen: valid/ready plus one input item
// depends on mprs_pkg for field widths

interface mprs_req_if;
   import mprs_pkg::*;

   logic              valid;
   logic              ready;
   logic [TYPE_W-1:0] req_type;
   char_type          char_value;
   logic              end_of_read;
   logic [IDX_W-1:0]  pattern_index;
   logic [POS_W-1:0]  char_position;
   logic [PLEN_W-1:0] pattern_length;

   modport source (
      output valid, req_type, char_value, end_of_read,
             pattern_index, char_position, pattern_length,
      input  ready
   );

   modport sink (
      input  valid, req_type, char_value, end_of_read,
             pattern_index, char_position, pattern_length,
      output ready
   );
endinterface

FILE: design/mprs_rsp_if.sv
// result channel of the read screen: valid/ready plus one result item
// depends on mprs_pkg for field widths

interface mprs_rsp_if;
   import mprs_pkg::*;

   logic             valid;
   logic             ready;
   logic             read_removed;
   logic [CNT_W-1:0] clean_count;
   logic [CNT_W-1:0] filtered_count;

   modport source (
      output valid, read_removed, clean_count, filtered_count,
      input  ready
   );

   modport sink (
      input  valid, read_removed, clean_count, filtered_count,
      output ready
   );
endinterface

FILE: design/mprs_win_cell.sv
// one character cell of the sliding read window, handed on to its neighbor
// depends on mprs_pkg

module mprs_win_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  mprs_pkg::shift_ctl_type ctl,
   input  mprs_pkg::char_type      left_char,
   output mprs_pkg::char_type      held_char,
   output mprs_pkg::char_type      view_char
);
   import mprs_pkg::*;

   char_type char_ff;
   char_type char_in;

   // view is the window after this cycle's shift, before the end-of-read clear
   always_comb begin
      view_char = ctl.shift ? left_char : char_ff;
      char_in   = ctl.clear ? '0 : view_char;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_ff <= '0;
      end else begin
         char_ff <= char_in;
      end
   end

   assign held_char = char_ff;

endmodule

FILE: design/mprs_pat_row.sv
// one pattern row: holds the pattern bytes and length, keeps a copy aligned
// to the window tail and compares it against the window; depends on mprs_pkg

module mprs_pat_row (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [mprs_pkg::ADDR_W-1:0] row_id,
   input  mprs_pkg::load_type          load,
   input  mprs_pkg::line_type          window,
   input  mprs_pkg::len_type           seen,
   output logic                        hit
);
   import mprs_pkg::*;

   char_type         pat_ff [MAX_LEN];
   char_type         pat_in [MAX_LEN];
   len_type          len_ff;
   len_type          len_in;
   line_type         al_ff;
   line_type         al_in;
   line_type         rev;
   logic             sel;
   logic [MAX_LEN-1:0] lane_ok;

   assign sel = (ADDR_W'(load.idx) == row_id);

   always_comb begin
      for (int k = 0; k < MAX_LEN; k++) begin
         pat_in[k] = (load.wr_char && sel && (int'(load.pos) == k)) ? load.ch : pat_ff[k];
      end
      for (int i = 0; i < MAX_LEN; i++) begin
         rev[i] = pat_in[MAX_LEN-1-i];
      end
      len_in = (load.wr_len && sel) ? load.len : len_ff;
      // lane k of the aligned copy holds pattern byte len-1-k
      al_in  = rev >> (CHAR_W * (MAX_LEN - int'(len_in)));
   end

   always_comb begin
      for (int k = 0; k < MAX_LEN; k++) begin
         lane_ok[k] = (k >= int'(len_ff)) || (window[k] == al_ff[k]);
      end
      hit = (len_ff != '0) && (len_ff <= seen) && (&lane_ok);
   end

   always_ff @(posedge clock) begin
      pat_ff <= pat_in;
      al_ff  <= al_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else begin
         len_ff <= len_in;
      end
   end

endmodule

FILE: design/multi_pattern_read_screen.sv
// top level of the multi-pattern read screen
// depends on mprs_pkg, mprs_req_if, mprs_rsp_if, mprs_win_cell, mprs_pat_row
//
// usage
//   req_if carries one item per handshake: a read character, a pattern
//   character write or a pattern length write (length zero disables a row)
//   rsp_if carries one item per finished read: removed flag plus the
//   saturating kept and removed read counts
//   throughput is one item per cycle while req_if.ready is high; every row
//   compares its pattern with the window tail in the cycle the char is accepted
//   the result of a read can be taken the cycle after its last character is
//   accepted
//   results go through a two-entry output queue, so the block keeps taking
//   items while one result waits; req_if.ready drops only while both entries
//   are full
//   reset disables all patterns and clears the window and both counts;
//   pattern bytes keep whatever they held and must be written before use
//   table writes take effect from the next read character on

module multi_pattern_read_screen (
   input  logic        clock,
   input  logic        reset,
   mprs_req_if.sink    req_if,
   mprs_rsp_if.source  rsp_if
);
   import mprs_pkg::*;

   localparam int FIFO_DEPTH = 2;
   localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

   // handshake decode
   logic accept;
   logic read_acc;
   logic last_acc;

   // table write command and window control
   load_type      load;
   shift_ctl_type wctl;

   // window chain
   char_type held [MAX_LEN];
   line_type view;

   // per-read state
   logic [PATTERNS-1:0] row_hit;
   len_type             seen_ff;
   len_type             seen_in;
   len_type             seen_next;
   logic                match_ff;
   logic                match_in;
   logic                match_now;
   logic [CNT_W-1:0]    kept_ff;
   logic [CNT_W-1:0]    kept_in;
   logic [CNT_W-1:0]    dropped_ff;
   logic [CNT_W-1:0]    dropped_in;

   // output queue
   result_type        fifo_ff [FIFO_DEPTH];
   result_type        result;
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [FCNT_W-1:0] cnt_ff;
   logic [FCNT_W-1:0] cnt_in;
   logic              push;
   logic              pop;

   assign req_if.ready = (cnt_ff != FCNT_W'(FIFO_DEPTH));
   assign accept       = req_if.valid && req_if.ready;
   assign read_acc     = accept && (req_if.req_type == REQ_READ);
   assign last_acc     = read_acc && req_if.end_of_read;

   // table writes, length saturated to the row size
   always_comb begin
      load.wr_char = accept && (req_if.req_type == REQ_WRITE_CHAR);
      load.wr_len  = accept && (req_if.req_type == REQ_SET_LEN);
      load.idx     = req_if.pattern_index;
      load.pos     = req_if.char_position;
      load.ch      = req_if.char_value;
      load.len     = (int'(req_if.pattern_length) > MAX_LEN) ?
                     LEN_W'(MAX_LEN) : LEN_W'(req_if.pattern_length);
   end

   assign wctl.shift = read_acc;
   assign wctl.clear = last_acc;

   // window: cell 0 takes the new character, each cell feeds the next
   for (genvar k = 0; k < MAX_LEN; k++) begin : g_win
      char_type left;
      if (k == 0) begin : g_head
         assign left = req_if.char_value;
      end else begin : g_body
         assign left = held[k-1];
      end
      mprs_win_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (wctl),
         .left_char (left),
         .held_char (held[k]),
         .view_char (view[k])
      );
   end

   // characters seen so far including this one, saturating at the row size
   assign seen_next = (int'(seen_ff) >= MAX_LEN) ? seen_ff : seen_ff + LEN_W'(1);

   // all rows compare in parallel
   for (genvar p = 0; p < PATTERNS; p++) begin : g_row
      mprs_pat_row u_row (
         .clock  (clock),
         .reset  (reset),
         .row_id (ADDR_W'(p)),
         .load   (load),
         .window (view),
         .seen   (seen_next),
         .hit    (row_hit[p])
      );
   end

   assign match_now = match_ff || (|row_hit);

   // saturating read counts
   always_comb begin
      kept_in    = kept_ff;
      dropped_in = dropped_ff;
      if (last_acc) begin
         if (match_now) begin
            if (dropped_ff != '1) begin
               dropped_in = dropped_ff + CNT_W'(1);
            end
         end else begin
            if (kept_ff != '1) begin
               kept_in = kept_ff + CNT_W'(1);
            end
         end
      end
   end

   // per-read state restarts after the last character
   always_comb begin
      seen_in  = seen_ff;
      match_in = match_ff;
      if (last_acc) begin
         seen_in  = '0;
         match_in = 1'b0;
      end else if (read_acc) begin
         seen_in  = seen_next;
         match_in = match_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff    <= '0;
         match_ff   <= 1'b0;
         kept_ff    <= '0;
         dropped_ff <= '0;
      end else begin
         seen_ff    <= seen_in;
         match_ff   <= match_in;
         kept_ff    <= kept_in;
         dropped_ff <= dropped_in;
      end
   end

   // output queue
   assign push            = last_acc;
   assign pop             = rsp_if.valid && rsp_if.ready;
   assign result.removed  = match_now;
   assign result.clean    = kept_in;
   assign result.filtered = dropped_in;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + FCNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - FCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         cnt_ff <= cnt_in;
      end
   end

   assign rsp_if.valid          = (cnt_ff != '0);
   assign rsp_if.read_removed   = fifo_ff[rd_ptr_ff].removed;
   assign rsp_if.clean_count    = fifo_ff[rd_ptr_ff].clean;
   assign rsp_if.filtered_count = fifo_ff[rd_ptr_ff].filtered;

   // checks

   // a finished read never lands on a full queue
   assert property (@(posedge clock) disable iff (reset)
      push |-> (cnt_ff != FCNT_W'(FIFO_DEPTH)))
      else $error("result pushed into full output queue");

   // the last character restarts the per-read state
   assert property (@(posedge clock) disable iff (reset)
      last_acc |=> (seen_ff == '0) && !match_ff)
      else $error("read state not restarted after last character");

   // counts move only when a read finishes
   assert property (@(posedge clock) disable iff (reset)
      !last_acc |=> (kept_ff == $past(kept_ff)) && (dropped_ff == $past(dropped_ff)))
      else $error("read count changed without a finished read");

   // below saturation exactly one count steps per finished read
   assert property (@(posedge clock) disable iff (reset)
      (last_acc && (kept_ff != '1) && (dropped_ff != '1)) |=>
      ((kept_ff - $past(kept_ff)) + (dropped_ff - $past(dropped_ff)) == CNT_W'(1)))
      else $error("finished read not counted exactly once");

   // character count stays within the window
   assert property (@(posedge clock) disable iff (reset)
      int'(seen_ff) <= MAX_LEN)
      else $error("character count beyond window size");

endmodule

FILE: sim/multi_pattern_read_screen_tb.sv
// self-checking bench for multi_pattern_read_screen: directed and random pattern
// loads and reads, every result checked against a screen predictor kept in the bench
// depends on mprs_pkg, mprs_req_if, mprs_rsp_if and multi_pattern_read_screen

module multi_pattern_read_screen_tb;
   import mprs_pkg::*;

   // request code the block does not know, it must be dropped silently
   localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;

   localparam int PLEN_MAX        = (1 << PLEN_W) - 1;
   localparam int HOLD_OFF_CYCLES = 40;     // long receiver stall, fills the result queue
   localparam int SETTLE_CYCLES   = 16;     // result shows the cycle after the last char
   localparam int STUCK_LIMIT     = 1000;   // cycles with no handshake at all
   localparam int MAX_REPORTS     = 10;

   // one request item as driven on the channel
   typedef struct {
      logic [TYPE_W-1:0] kind;
      char_type          ch;
      logic              last;
      logic [IDX_W-1:0]  row;
      logic [POS_W-1:0]  pos;
      logic [PLEN_W-1:0] plen;
   } screen_item_type;

   logic clock;
   logic reset;

   mprs_req_if req_ch ();
   mprs_rsp_if rsp_ch ();

   multi_pattern_read_screen u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // predictor copy of the pattern table and of the current read
   char_type           pat_bytes   [PATTERNS][MAX_LEN];
   logic [MAX_LEN-1:0] pat_written [PATTERNS];   // guards against enabling unwritten bytes
   int unsigned        pat_len     [PATTERNS];
   char_type           win_chars   [MAX_LEN];    // [0] is the newest char
   int unsigned        win_fill;
   bit                 hit_in_read;
   logic [CNT_W-1:0]   kept_total;
   logic [CNT_W-1:0]   dropped_total;

   // verdicts still owed by the block, oldest first
   result_type screen_results [$];

   // run bookkeeping
   int error_count;
   int items_sent;
   int useful_items;
   int loads_done;
   int reads_removed;
   int reads_kept;
   int results_seen;
   int input_stalls;
   int stuck_cycles;

   // idling controls
   bit src_gaps;
   bit sink_gaps;
   int sink_hold;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------

   // applies one accepted item; a closing read char queues its verdict
   function automatic void screen_model(input screen_item_type it);
      int unsigned plen;
      bit          same;
      result_type  res;
      case (it.kind)
         REQ_WRITE_CHAR: begin
            pat_bytes[it.row][it.pos]   = it.ch;
            pat_written[it.row][it.pos] = 1'b1;
            loads_done++;
         end
         REQ_SET_LEN: begin
            // lengths past the row size clamp to a full row
            pat_len[it.row] = (it.plen > MAX_LEN) ? MAX_LEN : it.plen;
            loads_done++;
         end
         REQ_READ: begin
            for (int j = MAX_LEN - 1; j > 0; j--) win_chars[j] = win_chars[j - 1];
            win_chars[0] = it.ch;
            if (win_fill < MAX_LEN) win_fill++;
            // every enabled row against the window tail; too long for the read so far
            // means no match yet
            for (int p = 0; p < PATTERNS; p++) begin
               plen = pat_len[p];
               if (plen != 0 && plen <= win_fill) begin
                  same = 1'b1;
                  for (int j = 0; j < plen; j++)
                     if (pat_bytes[p][j] != win_chars[plen - 1 - j]) same = 1'b0;
                  if (same) hit_in_read = 1'b1;
               end
            end
            if (it.last) begin
               // both counts hold at all ones
               if (hit_in_read) begin
                  if (dropped_total != '1) dropped_total++;
                  reads_removed++;
               end else begin
                  if (kept_total != '1) kept_total++;
                  reads_kept++;
               end
               res.removed  = hit_in_read;
               res.clean    = kept_total;
               res.filtered = dropped_total;
               screen_results.push_back(res);
               for (int j = 0; j < MAX_LEN; j++) win_chars[j] = '0;
               win_fill    = 0;
               hit_in_read = 1'b0;
            end
         end
         default: ;   // unknown request, nothing changes
      endcase
   endfunction

   // number of leading bytes of a row that have been written
   function automatic int written_prefix(input int row);
      int n;
      n = 0;
      while (n < MAX_LEN && pat_written[row][n]) n++;
      return n;
   endfunction

   // a length that never exposes an unwritten byte; full rows may use the clamp range
   function automatic int safe_len(input int row);
      int eff;
      eff = $urandom_range(0, written_prefix(row));
      return (eff == MAX_LEN) ? $urandom_range(MAX_LEN, PLEN_MAX) : eff;
   endfunction

   // dna letters make short patterns hit often, wide mode covers every byte
   function automatic char_type pick_char(input bit dna);
      if (!dna) return CHAR_W'($urandom_range(0, 255));
      case ($urandom_range(0, 3))
         0: return 8'h41;
         1: return 8'h43;
         2: return 8'h47;
         default: return 8'h54;
      endcase
   endfunction

   function automatic void note_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("t=%0t %s", $time, msg);
   endfunction

   function automatic void note_field(input string name, input logic [CNT_W-1:0] want,
                                      input logic [CNT_W-1:0] got);
      if (got !== want)
         note_error($sformatf("%s mismatch: expected %0d, got %0d", name, want, got));
   endfunction

   // ------------------------------------------------------------------
   // result checker, receiver stalls and watchdog
   // ------------------------------------------------------------------

   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         if (screen_results.size() == 0) begin
            note_error($sformatf("result with none expected: removed %0b clean %0d filtered %0d",
                                 rsp_ch.read_removed, rsp_ch.clean_count,
                                 rsp_ch.filtered_count));
         end else begin
            want = screen_results.pop_front();
            note_field("read_removed", CNT_W'(want.removed), CNT_W'(rsp_ch.read_removed));
            note_field("clean_count", want.clean, rsp_ch.clean_count);
            note_field("filtered_count", want.filtered, rsp_ch.filtered_count);
         end
      end
   end

   // receiver: a requested long hold first, else random bursts with ready low
   initial begin : drive_rsp_ready
      int gap_left;
      gap_left     = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (sink_hold > 0) begin
            sink_hold--;
            rsp_ch.ready = 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            rsp_ch.ready = 1'b0;
         end else if (sink_gaps && $urandom_range(0, 7) == 0) begin
            gap_left     = $urandom_range(1, 3) - 1;
            rsp_ch.ready = 1'b0;
         end else begin
            rsp_ch.ready = 1'b1;
         end
      end
   end

   // any handshake counts as progress
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) stuck_cycles = 0;
      else stuck_cycles++;
      if (req_ch.valid && !req_ch.ready) input_stalls++;
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("no handshake for %0d cycles, giving up", STUCK_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // item senders
   // ------------------------------------------------------------------

   // drives one item at the falling edge, holds it until taken, then predicts
   task automatic send_item(input screen_item_type it);
      if (src_gaps && $urandom_range(0, 9) == 0) begin
         @(negedge clock);
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 3) - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid          = 1'b1;
      req_ch.req_type       = it.kind;
      req_ch.char_value     = it.ch;
      req_ch.end_of_read    = it.last;
      req_ch.pattern_index  = it.row;
      req_ch.char_position  = it.pos;
      req_ch.pattern_length = it.plen;
      do @(posedge clock); while (!req_ch.ready);
      screen_model(it);
      items_sent++;
      if (it.kind != REQ_UNUSED) useful_items++;
   endtask

   // read char; the load-only fields carry noise
   task automatic send_char(input char_type ch, input logic last);
      screen_item_type it;
      it.kind = REQ_READ;
      it.ch   = ch;
      it.last = last;
      it.row  = IDX_W'($urandom_range(0, PATTERNS - 1));
      it.pos  = POS_W'($urandom_range(0, MAX_LEN - 1));
      it.plen = PLEN_W'($urandom_range(0, PLEN_MAX));
      send_item(it);
   endtask

   // end flag is random, a load must never close a read
   task automatic write_pattern_char(input int row, input int pos, input char_type ch);
      screen_item_type it;
      it.kind = REQ_WRITE_CHAR;
      it.ch   = ch;
      it.last = 1'($urandom_range(0, 1));
      it.row  = IDX_W'(row);
      it.pos  = POS_W'(pos);
      it.plen = PLEN_W'($urandom_range(0, PLEN_MAX));
      send_item(it);
   endtask

   task automatic set_pattern_len(input int row, input int plen);
      screen_item_type it;
      it.kind = REQ_SET_LEN;
      it.ch   = CHAR_W'($urandom_range(0, 255));
      it.last = 1'($urandom_range(0, 1));
      it.row  = IDX_W'(row);
      it.pos  = POS_W'($urandom_range(0, MAX_LEN - 1));
      it.plen = PLEN_W'(plen);
      send_item(it);
   endtask

   task automatic send_unused(input logic last);
      screen_item_type it;
      it.kind = REQ_UNUSED;
      it.ch   = CHAR_W'($urandom_range(0, 255));
      it.last = last;
      it.row  = IDX_W'($urandom_range(0, PATTERNS - 1));
      it.pos  = POS_W'($urandom_range(0, MAX_LEN - 1));
      it.plen = PLEN_W'($urandom_range(0, PLEN_MAX));
      send_item(it);
   endtask

   task automatic send_text(input string s, input bit close);
      for (int i = 0; i < s.len(); i++) send_char(s[i], close && i == s.len() - 1);
   endtask

   // lowers valid and holds the sender until every verdict is in
   task automatic wait_for_results();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (screen_results.size() != 0) @(posedge clock);
   endtask

   // stray item dropped into the middle of a read
   task automatic send_noise();
      int row;
      row = $urandom_range(0, PATTERNS - 1);
      case ($urandom_range(0, 2))
         0: send_unused(1'($urandom_range(0, 1)));
         1: write_pattern_char(row, $urandom_range(0, MAX_LEN - 1),
                               pick_char(1'($urandom_range(0, 1))));
         default: set_pattern_len(row, safe_len(row));
      endcase
   endtask

   // writes a fresh pattern into a row, then enables it
   task automatic load_random_pattern(input int row, input bit full);
      int len;
      bit dna;
      if (full) len = MAX_LEN;
      else if ($urandom_range(0, 7) == 0) len = $urandom_range(1, 2);
      else len = $urandom_range(3, 10);
      dna = ($urandom_range(0, 2) != 0);
      for (int pos = 0; pos < len; pos++) write_pattern_char(row, pos, pick_char(dna));
      set_pattern_len(row, (len == MAX_LEN) ? $urandom_range(MAX_LEN, PLEN_MAX) : len);
   endtask

   // random read, often carrying an enabled pattern or a one-bit near miss of it
   task automatic random_read(input bit noisy);
      char_type body [$];
      int       n;
      int       row;
      int       plen;
      int       at;
      bit       dna;
      dna = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: n = $urandom_range(1, 12);
         6, 7, 8:          n = $urandom_range(13, MAX_LEN);
         default:          n = $urandom_range(MAX_LEN + 1, 80);   // window wraps
      endcase
      for (int i = 0; i < n; i++) body.push_back(pick_char(dna));
      if ($urandom_range(0, 2) != 0) begin
         for (int tries = 0; tries < 4; tries++) begin
            row  = $urandom_range(0, PATTERNS - 1);
            plen = pat_len[row];
            if (plen != 0 && plen <= n) begin
               at = $urandom_range(0, n - plen);
               for (int j = 0; j < plen; j++) body[at + j] = pat_bytes[row][j];
               if ($urandom_range(0, 3) == 0)
                  body[at + plen - 1] = body[at + plen - 1] ^ (8'h01 << $urandom_range(0, 7));
               break;
            end
         end
      end
      for (int i = 0; i < n; i++) begin
         if (noisy && i > 0 && $urandom_range(0, 24) == 0) send_noise();
         send_char(body[i], i == n - 1);
      end
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   task automatic test_directed_cases();
      screen_item_type it;
      // empty table: every read is kept
      send_text("Z", 1);
      // extreme byte values as a two-char pattern, found at the end of a longer read
      write_pattern_char(0, 0, 8'h00);
      write_pattern_char(0, 1, 8'hFF);
      set_pattern_len(0, 2);
      send_char(8'h71, 1'b0);
      send_char(8'h00, 1'b0);
      send_char(8'hFF, 1'b1);
      // pattern longer than the read cannot match
      for (int pos = 0; pos < 3; pos++) write_pattern_char(1, pos, 8'h47);
      set_pattern_len(1, 3);
      send_text("GG", 1);
      // unknown request with the end flag set gives no verdict
      send_unused(1'b1);
      // end flag on a load is ignored
      it.kind = REQ_WRITE_CHAR;
      it.ch   = 8'h54;
      it.last = 1'b1;
      it.row  = IDX_W'(2);
      it.pos  = '0;
      it.plen = PLEN_W'(PLEN_MAX);
      send_item(it);
      // a row enabled mid-read only sees chars from the next one on
      send_text("TG", 0);
      set_pattern_len(2, 1);
      send_text("C", 1);
      // a hit stays with the read even if its row is disabled before the end
      send_char(8'h00, 1'b0);
      send_char(8'hFF, 1'b0);
      set_pattern_len(0, 0);
      send_text("A", 1);
   endtask

   task automatic test_random_screening(input int target);
      int start;
      start = useful_items;
      for (int row = 3; row < 7; row++) load_random_pattern(row, 1'b0);
      while (useful_items - start < target) begin
         case ($urandom_range(0, 19))
            0, 1:    load_random_pattern($urandom_range(0, PATTERNS - 1),
                                         $urandom_range(0, 5) == 0);
            2:       set_pattern_len($urandom_range(0, PATTERNS - 1), 0);
            default: random_read(1'b1);
         endcase
      end
   endtask

   // receiver stops for a long stretch while one-char reads keep coming, so the
   // result queue fills and the block has to refuse input
   task automatic test_output_holdoff();
      src_gaps  = 1'b0;
      sink_hold = HOLD_OFF_CYCLES;
      repeat (24) send_char(pick_char(1'b1), 1'b1);
      src_gaps = 1'b1;
   endtask

   // sender goes quiet after each read until the block has answered
   task automatic test_sender_pause();
      repeat (6) begin
         random_read(1'b0);
         wait_for_results();
      end
   endtask

   // full-row patterns, clamped lengths and a window that has wrapped
   task automatic test_long_patterns();
      load_random_pattern(15, 1'b1);
      load_random_pattern(14, 1'b1);
      // read equal to the row, the hit lands on its last char
      for (int j = 0; j < MAX_LEN; j++) send_char(pat_bytes[15][j], j == MAX_LEN - 1);
      // one char short of the row
      for (int j = 0; j < MAX_LEN - 1; j++) send_char(pat_bytes[15][j], j == MAX_LEN - 2);
      // long read with the row at its very end
      repeat (28) send_char(pick_char(1'b0), 1'b0);
      for (int j = 0; j < MAX_LEN; j++) send_char(pat_bytes[14][j], j == MAX_LEN - 1);
      repeat (4) random_read(1'b1);
   endtask

   // closing stretch at full rate on both sides
   task automatic test_gapless_stream(input int target);
      src_gaps  = 1'b0;
      sink_gaps = 1'b0;
      test_random_screening(target);
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------

   initial begin
      reset                 = 1'b1;
      req_ch.valid          = 1'b0;
      req_ch.req_type       = REQ_READ;
      req_ch.char_value     = '0;
      req_ch.end_of_read    = 1'b0;
      req_ch.pattern_index  = '0;
      req_ch.char_position  = '0;
      req_ch.pattern_length = '0;
      src_gaps      = 1'b1;
      sink_gaps     = 1'b1;
      sink_hold     = 0;
      error_count   = 0;
      items_sent    = 0;
      useful_items  = 0;
      loads_done    = 0;
      reads_removed = 0;
      reads_kept    = 0;
      results_seen  = 0;
      input_stalls  = 0;
      stuck_cycles  = 0;
      // bench view of the state after reset; pattern bytes count as unwritten
      for (int p = 0; p < PATTERNS; p++) begin
         pat_len[p]     = 0;
         pat_written[p] = '0;
         for (int j = 0; j < MAX_LEN; j++) pat_bytes[p][j] = '0;
      end
      for (int j = 0; j < MAX_LEN; j++) win_chars[j] = '0;
      win_fill      = 0;
      hit_in_read   = 1'b0;
      kept_total    = '0;
      dropped_total = '0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_cases();
      test_random_screening(1200);
      test_output_holdoff();
      test_sender_pause();
      test_long_patterns();
      test_gapless_stream(350);

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (screen_results.size() != 0)
         note_error($sformatf("%0d verdicts never arrived", screen_results.size()));

      $display("screened %0d reads (%0d removed, %0d kept) in %0d items, %0d of them table loads",
               reads_removed + reads_kept, reads_removed, reads_kept, items_sent, loads_done);
      $display("input refused for %0d cycles under output stalls; %0d results checked, %0d errors",
               input_stalls, results_seen, error_count);
      if (error_count == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: sim.f
design/mprs_pkg.sv
design/mprs_req_if.sv
design/mprs_rsp_if.sv
design/mprs_win_cell.sv
design/mprs_pat_row.sv
design/multi_pattern_read_screen.sv
sim/multi_pattern_read_screen_tb.sv
